[rtl/image_header_stream_parser_macros.svh]
// Assertion macros used by the image header stream parser checker.
`ifndef IMAGE_HEADER_STREAM_PARSER_MACROS_SVH
`define IMAGE_HEADER_STREAM_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IHSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ihsp_pkg.sv]
// Shared types and constants of the image header stream parser.
`default_nettype none

package ihsp_pkg;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_MAGIC,
      PH_HDR,
      PH_CONT,
      PH_WID,
      PH_HGT,
      PH_CAPTION,
      PH_TAGS,
      PH_PIXELS,
      PH_DONE,
      PH_HALT
   } phase_type;

   typedef enum logic [3:0] {
      KIND_HDRSIZE      = 4'd0,
      KIND_CONTENTSIZE  = 4'd1,
      KIND_WIDTH        = 4'd2,
      KIND_HEIGHT       = 4'd3,
      KIND_CAPTION      = 4'd4,
      KIND_TAGCHAR      = 4'd5,
      KIND_TAGEND       = 4'd6,
      KIND_PIXEL        = 4'd7,
      KIND_BADMAGIC     = 4'd8,
      KIND_SIZEMISMATCH = 4'd9
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] value;
      logic        last;
   } result_type;

   localparam logic [63:0] MAGIC_WORD         = 64'h0000_0000_4646_4943;
   localparam logic [63:0] FIXED_HEADER_BYTES = 64'd36;
   localparam logic [63:0] PIXEL_BYTES        = 64'd3;
   localparam logic [63:0] TWO_PIXEL_BYTES    = 64'd6;
   localparam logic [7:0]  CHAR_NEWLINE       = 8'h0A;
   localparam logic [7:0]  CHAR_NUL           = 8'h00;
   localparam logic [2:0]  MAGIC_LAST_POS     = 3'd3;
   localparam logic [2:0]  FIELD_LAST_POS     = 3'd7;
   localparam logic [2:0]  PIXEL_RED_POS      = 3'd0;
   localparam logic [2:0]  PIXEL_GREEN_POS    = 3'd1;
   localparam logic [2:0]  PIXEL_BLUE_POS     = 3'd2;
   localparam int          QUEUE_DEPTH_DEF    = 4;

endpackage

`default_nettype wire

[rtl/ihsp_queue.sv]
// Small result queue between the parser front end and the output stage.
`default_nettype none

module ihsp_queue #(
   parameter int DEPTH = ihsp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ihsp_pkg::result_type push_data,
   input  wire logic                 pop,
   output      ihsp_pkg::result_type pop_data,
   output      logic                 full,
   output      logic                 not_empty
);
   import ihsp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type        entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/ihsp_front.sv]
// Parser front end: takes file bytes, tracks the parse phase, builds results.
`default_nettype none

module ihsp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_data,
   input  wire logic                 in_first,
   input  wire logic                 in_ready,
   output      logic                 push,
   output      ihsp_pkg::result_type push_data
);
   import ihsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [63:0] field_ff, field_in;
   logic [63:0] hl_ff, hl_in;
   logic [63:0] cl_ff, cl_in;
   logic [63:0] w3_ff, w3_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] hc_ff, hc_in;
   logic [63:0] rem_ff, rem_in;
   logic [15:0] pp_ff, pp_in;

   logic        fire;
   phase_type   cur_phase;
   logic [2:0]  cur_pos;
   logic [63:0] cur_field;
   logic [63:0] byte_ext;
   logic [63:0] assembled;
   logic [71:0] hgt_mul;
   logic [63:0] hgt_term;
   logic [63:0] prod_sum;
   logic [63:0] hc_inc;
   phase_type   content_phase;

   assign fire          = in_valid && in_ready;
   assign cur_phase     = in_first ? PH_MAGIC : phase_ff;
   assign cur_pos       = in_first ? 3'd0 : pos_ff;
   assign cur_field     = in_first ? 64'd0 : field_ff;
   assign byte_ext      = {56'd0, in_data};
   assign assembled     = cur_field | (byte_ext << {cur_pos, 3'b000});
   // width*3 times one height byte, placed at that byte's weight
   assign hgt_mul       = w3_ff * in_data;
   assign hgt_term      = hgt_mul[63:0] << {cur_pos, 3'b000};
   assign prod_sum      = prod_ff + hgt_term;
   assign hc_inc        = hc_ff + 64'd1;
   assign content_phase = (cl_ff >= PIXEL_BYTES) ? PH_PIXELS : PH_DONE;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      field_in  = field_ff;
      hl_in     = hl_ff;
      cl_in     = cl_ff;
      w3_in     = w3_ff;
      prod_in   = prod_ff;
      hc_in     = hc_ff;
      rem_in    = rem_ff;
      pp_in     = pp_ff;
      push      = 1'b0;
      push_data = '{kind: KIND_HDRSIZE, value: 64'd0, last: 1'b0};

      if (fire) begin
         phase_in = cur_phase;
         pos_in   = cur_pos;
         field_in = cur_field;
         case (cur_phase)
            PH_MAGIC: begin
               field_in = assembled;
               pos_in   = cur_pos + 3'd1;
               if (cur_pos == MAGIC_LAST_POS) begin
                  field_in = 64'd0;
                  pos_in   = 3'd0;
                  if (assembled != MAGIC_WORD) begin
                     push      = 1'b1;
                     push_data = '{kind: KIND_BADMAGIC, value: assembled, last: 1'b1};
                     phase_in  = PH_HALT;
                  end else begin
                     phase_in = PH_HDR;
                  end
               end
            end
            PH_HDR, PH_CONT, PH_WID, PH_HGT: begin
               field_in = assembled;
               pos_in   = cur_pos + 3'd1;
               if (cur_phase == PH_HGT) begin
                  prod_in = prod_sum;
               end
               if (cur_pos == FIELD_LAST_POS) begin
                  field_in = 64'd0;
                  pos_in   = 3'd0;
                  push     = 1'b1;
                  case (cur_phase)
                     PH_HDR: begin
                        hl_in     = assembled;
                        push_data = '{kind: KIND_HDRSIZE, value: assembled, last: 1'b0};
                        phase_in  = PH_CONT;
                     end
                     PH_CONT: begin
                        cl_in     = assembled;
                        push_data = '{kind: KIND_CONTENTSIZE, value: assembled, last: 1'b0};
                        phase_in  = PH_WID;
                     end
                     PH_WID: begin
                        w3_in     = assembled + {assembled[62:0], 1'b0};
                        prod_in   = 64'd0;
                        push_data = '{kind: KIND_WIDTH, value: assembled, last: 1'b0};
                        phase_in  = PH_HGT;
                     end
                     default: begin
                        if (prod_sum != cl_ff) begin
                           push_data = '{kind: KIND_SIZEMISMATCH, value: prod_sum,
                                         last: 1'b1};
                           phase_in  = PH_HALT;
                        end else begin
                           push_data = '{kind: KIND_HEIGHT, value: assembled, last: 1'b0};
                           hc_in     = FIXED_HEADER_BYTES;
                           phase_in  = PH_CAPTION;
                        end
                     end
                  endcase
               end
            end
            PH_CAPTION: begin
               hc_in     = hc_inc;
               push      = 1'b1;
               push_data = '{kind: KIND_CAPTION, value: byte_ext, last: 1'b0};
               if (in_data == CHAR_NEWLINE) begin
                  if (hc_inc >= hl_ff) begin
                     pos_in   = 3'd0;
                     rem_in   = cl_ff;
                     phase_in = content_phase;
                  end else begin
                     phase_in = PH_TAGS;
                  end
               end
            end
            PH_TAGS: begin
               hc_in = hc_inc;
               push  = 1'b1;
               if (in_data == CHAR_NUL) begin
                  push_data = '{kind: KIND_TAGEND, value: 64'd0, last: 1'b0};
               end else begin
                  push_data = '{kind: KIND_TAGCHAR, value: byte_ext, last: 1'b0};
               end
               if (hc_inc >= hl_ff) begin
                  pos_in   = 3'd0;
                  rem_in   = cl_ff;
                  phase_in = content_phase;
               end
            end
            PH_PIXELS: begin
               case (cur_pos)
                  PIXEL_RED_POS: begin
                     pp_in  = {in_data, 8'd0};
                     pos_in = PIXEL_GREEN_POS;
                  end
                  PIXEL_GREEN_POS: begin
                     pp_in  = {pp_ff[15:8], in_data};
                     pos_in = PIXEL_BLUE_POS;
                  end
                  default: begin
                     // rem_ff counts content bytes not yet in a finished pixel
                     push      = 1'b1;
                     push_data = '{kind: KIND_PIXEL, value: {40'd0, pp_ff, in_data},
                                   last: (rem_ff < TWO_PIXEL_BYTES)};
                     rem_in    = rem_ff - PIXEL_BYTES;
                     pp_in     = 16'd0;
                     pos_in    = PIXEL_RED_POS;
                     if (rem_ff < TWO_PIXEL_BYTES) begin
                        phase_in = PH_DONE;
                     end
                  end
               endcase
            end
            default: begin
               // idle, done or halted: drop the byte
               phase_in = cur_phase;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= 3'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      field_ff <= field_in;
      hl_ff    <= hl_in;
      cl_ff    <= cl_in;
      w3_ff    <= w3_in;
      prod_ff  <= prod_in;
      hc_ff    <= hc_in;
      rem_ff   <= rem_in;
      pp_ff    <= pp_in;
   end

endmodule

`default_nettype wire

[rtl/ihsp_back.sv]
// Output stage: moves queued results into the result stream register.
`default_nettype none

module ihsp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire ihsp_pkg::result_type q_data,
   output      logic                 q_pop,
   output      logic                 out_valid,
   input  wire logic                 out_ready,
   output      ihsp_pkg::result_type out_data
);
   import ihsp_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // load whenever the register is empty or its beat is taken this cycle
   assign q_pop     = q_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         data_in  = q_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

[rtl/image_header_stream_parser.sv]
// Image header stream parser: one file byte per beat in, parse results out.
// Throughput: one byte per cycle while results are taken; a byte yields at most one result.
// A result is written into the queue, then into the output register, which drives rsp.
// The size check folds width*3 times each height byte in as it arrives.
// Reset (synchronous, active high) returns the parse to idle and empties the queue.
`default_nettype none

module image_header_stream_parser #(
   parameter int QUEUE_DEPTH = ihsp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] first
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // [63:0] value
   output      logic [3:0]  rsp_tuser,   // [3:0] kind
   output      logic        rsp_tlast    // last
);
   import ihsp_pkg::*;

   logic       push;
   result_type push_data;
   logic       pop;
   result_type pop_data;
   logic       q_full;
   logic       q_not_empty;
   result_type out_data;

   assign req_tready = !q_full;

   ihsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .in_first  (req_tuser),
      .in_ready  (req_tready),
      .push      (push),
      .push_data (push_data)
   );

   ihsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   ihsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data.value;
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.last;

endmodule

`default_nettype wire

[rtl/ihsp_checker.sv]
// Port-level checker for the image header stream parser, bound to the top level.
`default_nettype none
`include "image_header_stream_parser_macros.svh"

module ihsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   import ihsp_pkg::*;

   logic unused_req;

   assign unused_req = req_tvalid ^ req_tready ^ (^req_tdata) ^ req_tuser;

   `IHSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result beat changed")

   `IHSP_ASSERT_NOW(a_last_kind, clock, reset, rsp_tvalid && rsp_tlast,
      rsp_tuser == KIND_PIXEL || rsp_tuser == KIND_BADMAGIC ||
      rsp_tuser == KIND_SIZEMISMATCH, "last set on a non-final kind")

   `IHSP_ASSERT_NOW(a_char_width, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_CAPTION || rsp_tuser == KIND_TAGCHAR),
      rsp_tdata[63:8] == 56'd0 && !rsp_tlast, "character beat wider than a byte")

   `IHSP_ASSERT_NOW(a_pixel_width, clock, reset, rsp_tvalid && rsp_tuser == KIND_PIXEL,
      rsp_tdata[63:24] == 40'd0, "pixel beat wider than three bytes")

   `IHSP_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid,
      "result valid right after reset")

endmodule

bind image_header_stream_parser ihsp_checker u_checker (.*);

`default_nettype wire
